// ----- sv/positional_list_insert_remove_top_macros.svh -----
// assertion macros for the positional list block
// used by the checker bound to the top level, expects clk and arst_n in scope
`ifndef POSITIONAL_LIST_INSERT_REMOVE_TOP_MACROS_SVH
`define POSITIONAL_LIST_INSERT_REMOVE_TOP_MACROS_SVH

// same-cycle implication
`define PLIR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PLIR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/plir_pkg.sv -----
// shared types and constants for the positional list block
// no dependencies
`default_nettype none

package plir_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W = 10;
	localparam int CNT_OUT_W = 9;
	localparam int STATUS_W = 2;
	localparam int CAPACITY_DEF = 256;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_POS = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_ROT,
		OP_SHL,
		OP_SHR
	} cell_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEEK,
		ST_EDIT,
		ST_RESTORE,
		ST_REPLY
	} ctrl_state_t;

	typedef struct packed {
		cell_op_t op;
		logic signed [DATA_W-1:0] ins_value;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/positional_list_insert_remove_top.sv -----
// a bad position or full list goes straight to the reply; otherwise the element row rotates
// one place per cycle: p - 1 places to the head, then the edit, then m places back, where p is
// the position and m the restore rotation (count - p, or count - p + 2 on insert; 0 if p is 1)
// throughput: one transaction at a time, next accepted the cycle after its result is registered
// reset: list empty, count zero, no result pending; cell contents are not cleared
`default_nettype none

module positional_list_insert_remove_top #(
	parameter int CAPACITY = plir_pkg::CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic req_type,
	input  logic [plir_pkg::POS_W-1:0] position,
	input  logic signed [plir_pkg::DATA_W-1:0] value,
	output logic out_valid,
	input  logic out_stall,
	output logic [plir_pkg::STATUS_W-1:0] status,
	output logic removed_valid,
	output logic signed [plir_pkg::DATA_W-1:0] removed_value,
	output logic [plir_pkg::CNT_OUT_W-1:0] element_count
);
	import plir_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	cell_ctrl_t cell_ctrl;
	logic [CW-1:0] len;
	logic signed [DATA_W-1:0] cell_val [CAPACITY];

	plir_ctrl #(
		.CAPACITY(CAPACITY),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.removed_valid(removed_valid),
		.removed_value(removed_value),
		.element_count(element_count),
		.head_value(cell_val[0]),
		.cell_ctrl(cell_ctrl),
		.len(len)
	);

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic signed [DATA_W-1:0] prev_v, next_v;

		if (k == 0) begin : g_first
			assign prev_v = cell_ctrl.ins_value;
		end else begin : g_mid
			assign prev_v = cell_val[k-1];
		end

		if (k == CAPACITY - 1) begin : g_last
			assign next_v = '0;
		end else begin : g_inner
			assign next_v = cell_val[k+1];
		end

		plir_cell #(
			.CW(CW),
			.INDEX(k)
		) u_cell (
			.clk(clk),
			.ctrl(cell_ctrl),
			.len(len),
			.prev_value(prev_v),
			.next_value(next_v),
			.head_value(cell_val[0]),
			.cell_value(cell_val[k])
		);
	end

endmodule

`default_nettype wire

// ----- sv/plir_cell.sv -----
// one storage cell of the list chain: holds one element, takes a neighbor on rotate or shift
// depends on plir_pkg
`default_nettype none

module plir_cell #(
	parameter int CW = 9,
	parameter int INDEX = 0
) (
	input  logic clk,
	input  plir_pkg::cell_ctrl_t ctrl,
	input  logic [CW-1:0] len,
	input  logic signed [plir_pkg::DATA_W-1:0] prev_value,
	input  logic signed [plir_pkg::DATA_W-1:0] next_value,
	input  logic signed [plir_pkg::DATA_W-1:0] head_value,
	output logic signed [plir_pkg::DATA_W-1:0] cell_value
);
	import plir_pkg::*;

	localparam logic [CW-1:0] IDX_V = CW'(INDEX);
	localparam logic [CW-1:0] NEXT_V = CW'(INDEX + 1);

	logic signed [DATA_W-1:0] value_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_ROT: begin
				if (IDX_V < len) begin
					value_q <= (NEXT_V == len) ? head_value : next_value;
				end
			end
			OP_SHL: begin
				if (IDX_V < len) begin
					value_q <= next_value;
				end
			end
			OP_SHR: begin
				if (IDX_V <= len) begin
					value_q <= prev_value;
				end
			end
			default: begin
			end
		endcase
	end

	assign cell_value = value_q;

endmodule

`default_nettype wire

// ----- sv/plir_ctrl.sv -----
// sequencer for the positional list: position checks, rotate counts, element count, result register
// depends on plir_pkg
`default_nettype none

module plir_ctrl #(
	parameter int CAPACITY = plir_pkg::CAPACITY_DEF,
	parameter int CW = 9
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic req_type,
	input  logic [plir_pkg::POS_W-1:0] position,
	input  logic signed [plir_pkg::DATA_W-1:0] value,
	output logic out_valid,
	input  logic out_stall,
	output logic [plir_pkg::STATUS_W-1:0] status,
	output logic removed_valid,
	output logic signed [plir_pkg::DATA_W-1:0] removed_value,
	output logic [plir_pkg::CNT_OUT_W-1:0] element_count,
	input  logic signed [plir_pkg::DATA_W-1:0] head_value,
	output plir_pkg::cell_ctrl_t cell_ctrl,
	output logic [CW-1:0] len
);
	import plir_pkg::*;

	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

	ctrl_state_t state_q, state_d;
	logic req_q;
	logic [POS_W-1:0] pos_q;
	logic signed [DATA_W-1:0] val_q;
	logic [CW-1:0] rot_q;
	logic [CW-1:0] count_q;
	logic [STATUS_W-1:0] status_q;
	logic rvalid_q;
	logic signed [DATA_W-1:0] rvalue_q;
	logic out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic out_rvalid_q;
	logic signed [DATA_W-1:0] out_rvalue_q;
	logic [CNT_OUT_W-1:0] out_count_q;

	logic [XW-1:0] pos_x, pos_q_x, cnt_x;
	logic [STATUS_W-1:0] chk_status;
	logic [XW-1:0] restore_x;
	logic accept, reply_load;

	assign pos_x = XW'(position);
	assign pos_q_x = XW'(pos_q);
	assign cnt_x = XW'(count_q);

	always_comb begin
		chk_status = STATUS_DONE;
		if (req_type == REQ_INSERT) begin
			if (position == '0 || pos_x > cnt_x + XW'(1)) begin
				chk_status = STATUS_BAD_POS;
			end else if (cnt_x == XW'(CAPACITY)) begin
				chk_status = STATUS_FULL;
			end
		end else begin
			if (position == '0 || pos_x > cnt_x) begin
				chk_status = STATUS_BAD_POS;
			end
		end
	end

	always_comb begin
		restore_x = '0;
		if (pos_q != POS_W'(1)) begin
			if (req_q == REQ_INSERT) begin
				restore_x = cnt_x - pos_q_x + XW'(2);
			end else begin
				restore_x = cnt_x - pos_q_x;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (chk_status == STATUS_DONE) ? ST_SEEK : ST_REPLY;
				end
			end
			ST_SEEK: begin
				if (rot_q == '0) begin
					state_d = ST_EDIT;
				end
			end
			ST_EDIT: begin
				state_d = ST_RESTORE;
			end
			ST_RESTORE: begin
				if (rot_q == '0) begin
					state_d = ST_REPLY;
				end
			end
			ST_REPLY: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_stall = 1'b1;
		reply_load = 1'b0;
		cell_ctrl.op = OP_HOLD;
		cell_ctrl.ins_value = val_q;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_SEEK, ST_RESTORE: begin
				if (rot_q != '0) begin
					cell_ctrl.op = OP_ROT;
				end
			end
			ST_EDIT: begin
				cell_ctrl.op = (req_q == REQ_INSERT) ? OP_SHR : OP_SHL;
			end
			ST_REPLY: begin
				reply_load = !out_valid_q || !out_stall;
			end
			default: begin
			end
		endcase
	end

	assign accept = in_valid && !in_stall;
	assign len = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EDIT) begin
				count_q <= (req_q == REQ_INSERT) ? count_q + CW'(1) : count_q - CW'(1);
			end
			if (reply_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			pos_q <= position;
			val_q <= value;
			status_q <= chk_status;
			rvalid_q <= 1'b0;
			rvalue_q <= '0;
			rot_q <= CW'(pos_x - XW'(1));
		end
		if ((state_q == ST_SEEK || state_q == ST_RESTORE) && rot_q != '0) begin
			rot_q <= rot_q - CW'(1);
		end
		if (state_q == ST_EDIT) begin
			rot_q <= CW'(restore_x);
			if (req_q == REQ_REMOVE) begin
				rvalid_q <= 1'b1;
				rvalue_q <= head_value;
			end
		end
		if (reply_load) begin
			out_status_q <= status_q;
			out_rvalid_q <= rvalid_q;
			out_rvalue_q <= rvalue_q;
			out_count_q <= CNT_OUT_W'(count_q);
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign removed_valid = out_rvalid_q;
	assign removed_value = out_rvalue_q;
	assign element_count = out_count_q;

endmodule

`default_nettype wire

// ----- sv/plir_checker.sv -----
// port-level checks for the positional list block, bound to the top level
// depends on plir_pkg and positional_list_insert_remove_top_macros.svh
`default_nettype none

`include "positional_list_insert_remove_top_macros.svh"

module plir_checker #(
	parameter int CAPACITY = plir_pkg::CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [plir_pkg::STATUS_W-1:0] status,
	input logic removed_valid,
	input logic signed [plir_pkg::DATA_W-1:0] removed_value,
	input logic [plir_pkg::CNT_OUT_W-1:0] element_count
);
	import plir_pkg::*;

	`PLIR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(removed_value) && $stable(element_count), "stalled result changed")

	`PLIR_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "input taken while busy")

	`PLIR_ASSERT_NOW(a_status_code, out_valid, status == STATUS_DONE || status == STATUS_BAD_POS || status == STATUS_FULL, "undefined status code")

	`PLIR_ASSERT_NOW(a_reject_clean, out_valid && status != STATUS_DONE, !removed_valid && removed_value == '0, "rejected transaction reports a removed value")

	`PLIR_ASSERT_NOW(a_full_count, out_valid && status == STATUS_FULL, element_count == CNT_OUT_W'(CAPACITY) && !removed_valid, "full status without a full list")

endmodule

bind positional_list_insert_remove_top plir_checker #(.CAPACITY(CAPACITY)) u_plir_checker (.*);

`default_nettype wire

// ----- tb/sv/positional_list_insert_remove_top_tb.sv -----
// testbench for positional_list_insert_remove_top: directed and random insert/remove traffic
// predicts each result from a queue-based list model and checks results field by field
// depends on plir_pkg and the top level rtl only
`default_nettype none

module positional_list_insert_remove_top_tb;
	import plir_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 300;

	typedef struct {
		logic op;
		logic [POS_W-1:0] pos;
		logic signed [DATA_W-1:0] val;
	} request_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic removed_valid;
		logic signed [DATA_W-1:0] removed_value;
		logic [CNT_OUT_W-1:0] element_count;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = REQ_INSERT;
	logic [POS_W-1:0] position = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic removed_valid;
	logic signed [DATA_W-1:0] removed_value;
	logic [CNT_OUT_W-1:0] element_count;

	request_t request_q[$];
	outcome_t outcome_q[$];
	logic signed [DATA_W-1:0] list_model[$];

	int gen_len = 0;
	int total_requests = 0;
	int accepted_count = 0;
	int results_seen = 0;
	int mismatches = 0;
	int n_inserted = 0;
	int n_removed = 0;
	int n_bad_pos = 0;
	int n_full = 0;
	int longest = 0;

	positional_list_insert_remove_top #(
		.CAPACITY(CAPACITY_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.removed_valid(removed_valid),
		.removed_value(removed_value),
		.element_count(element_count)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("%0t mismatch on result %0d: %s got %0h expected %0h",
			$realtime, results_seen, field, got, want);
	endtask

	// list model: the queue index is the position minus one
	function automatic void apply_request(input logic op, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] val);
		outcome_t res;
		int len;
		len = list_model.size();
		res.status = STATUS_DONE;
		res.removed_valid = 1'b0;
		res.removed_value = '0;
		if (op == REQ_INSERT) begin
			if (pos == 0 || pos > len + 1) begin
				res.status = STATUS_BAD_POS;
				n_bad_pos++;
			end else if (len >= CAPACITY_DEF) begin
				res.status = STATUS_FULL;
				n_full++;
			end else begin
				list_model.insert(pos - 1, val);
				n_inserted++;
			end
		end else begin
			if (pos == 0 || pos > len) begin
				res.status = STATUS_BAD_POS;
				n_bad_pos++;
			end else begin
				res.removed_valid = 1'b1;
				res.removed_value = list_model[pos - 1];
				list_model.delete(pos - 1);
				n_removed++;
			end
		end
		res.element_count = CNT_OUT_W'(list_model.size());
		if (list_model.size() > longest)
			longest = list_model.size();
		outcome_q.push_back(res);
	endfunction

	function automatic bit take_idle();
		bit steady;
		steady = accepted_count >= 300 && accepted_count < 450;
		return !steady && ($urandom_range(0, 99) < 32);
	endfunction

	task automatic queue_request(input logic op, input int pos, input logic signed [DATA_W-1:0] val);
		request_t r;
		r.op = op;
		r.pos = POS_W'(pos);
		r.val = val;
		request_q.push_back(r);
		total_requests++;
		if (op == REQ_INSERT) begin
			if (pos != 0 && pos <= gen_len + 1 && gen_len < CAPACITY_DEF)
				gen_len++;
		end else if (pos != 0 && pos <= gen_len) begin
			gen_len--;
		end
	endtask

	function automatic int valid_position(input logic op);
		int top;
		top = (op == REQ_INSERT) ? gen_len + 1 : gen_len;
		if (top == 0)
			return 1;
		case ($urandom_range(0, 3))
			0: return 1;
			1: return top;
			default: return $urandom_range(1, top);
		endcase
	endfunction

	task automatic queue_mixed(input int ins_pct, input int rem_pct);
		int r;
		logic op;
		r = $urandom_range(0, 99);
		if (r < ins_pct) begin
			queue_request(REQ_INSERT, valid_position(REQ_INSERT), $urandom);
		end else if (r < ins_pct + rem_pct) begin
			queue_request(REQ_REMOVE, valid_position(REQ_REMOVE), $urandom);
		end else begin
			op = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 2))
				0: queue_request(op, 0, $urandom);
				1: queue_request(op, (op == REQ_INSERT) ? gen_len + 2 : gen_len + 1, $urandom);
				default: queue_request(op, $urandom_range(0, 1023), $urandom);
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_proc
		request_t next_req;
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= REQ_INSERT;
			position <= '0;
			value <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				apply_request(req_type, position, value);
				accepted_count++;
			end
			if (!in_valid || !in_stall) begin
				if (request_q.size() != 0 && !take_idle()) begin
					next_req = request_q.pop_front();
					in_valid <= 1'b1;
					req_type <= next_req.op;
					position <= next_req.pos;
					value <= next_req.val;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_proc
		outcome_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (outcome_q.size() == 0) begin
					report_mismatch("unexpected transaction, status", 32'(status), 32'(0));
				end else begin
					want = outcome_q.pop_front();
					if (status !== want.status)
						report_mismatch("status", 32'(status), 32'(want.status));
					if (removed_valid !== want.removed_valid)
						report_mismatch("removed_valid", 32'(removed_valid),
							32'(want.removed_valid));
					if (removed_value !== want.removed_value)
						report_mismatch("removed_value", removed_value, want.removed_value);
					if (element_count !== want.element_count)
						report_mismatch("element_count", 32'(element_count),
							32'(want.element_count));
				end
			end
			out_stall <= take_idle();
		end
	end

	initial begin
		// directed: empty list, position zero, beyond end, value extremes, head/middle/tail
		queue_request(REQ_REMOVE, 1, 32'hdeadbeef);
		queue_request(REQ_INSERT, 0, 32'h1234_5678);
		queue_request(REQ_REMOVE, 0, '0);
		queue_request(REQ_INSERT, 2, 32'h0000_0001);
		queue_request(REQ_INSERT, 1, 32'h7fff_ffff);
		queue_request(REQ_INSERT, 2, 32'h8000_0000);
		queue_request(REQ_INSERT, 1, 32'h0000_0000);
		queue_request(REQ_INSERT, 2, 32'hffff_ffff);
		queue_request(REQ_INSERT, 6, 32'h2222_2222);
		queue_request(REQ_INSERT, 1023, 32'h5555_5555);
		queue_request(REQ_REMOVE, 5, 32'haaaa_aaaa);
		queue_request(REQ_REMOVE, 1023, 32'hffff_ffff);
		queue_request(REQ_REMOVE, 4, 32'hdeadbeef);
		queue_request(REQ_REMOVE, 2, '0);
		queue_request(REQ_REMOVE, 1, '0);
		queue_request(REQ_REMOVE, 1, '0);
		queue_request(REQ_REMOVE, 1, '0);

		repeat (200) queue_mixed(55, 35);
		while (gen_len < CAPACITY_DEF)
			queue_mixed(85, 5);
		// full list: valid inserts report full, bad positions are still rejected first
		queue_request(REQ_INSERT, CAPACITY_DEF + 2, $urandom);
		queue_request(REQ_INSERT, 0, $urandom);
		queue_request(REQ_INSERT, CAPACITY_DEF + 1, $urandom);
		repeat (20) queue_mixed(60, 20);
		while (gen_len > 0)
			queue_mixed(5, 85);
		while (total_requests < 800)
			queue_mixed(50, 40);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_count < total_requests || outcome_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d transactions: %0d inserts, %0d removes, %0d bad positions, %0d full",
			accepted_count, n_inserted, n_removed, n_bad_pos, n_full);
		$display("longest list %0d of %0d entries, %0d results checked",
			longest, CAPACITY_DEF, results_seen);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout with %0d results outstanding", outcome_q.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire

// ----- positional_list_insert_remove_top.f -----
+incdir+sv
sv/plir_pkg.sv
sv/plir_cell.sv
sv/plir_ctrl.sv
sv/positional_list_insert_remove_top.sv
sv/plir_checker.sv
tb/sv/positional_list_insert_remove_top_tb.sv
